// ----- src/pdr_pkg.sv -----
`default_nettype none

package pdr_pkg;

   // Field widths.
   localparam int AMOUNT_W = 17;
   localparam int HEAD_W   = 17;
   localparam int POS_W    = 32;

   // Number of CORDIC micro-rotations (12 .. 32).
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ATAN_DEPTH   = 32;
   localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

   // One full turn in 1/256 degree.
   localparam logic [HEAD_W-1:0] TURN_UNITS = 17'd92160;

   // Heading to binary angle: 92160 = 2^11 * 45, so b = (h / 45) * 2^21 + frac(h % 45).
   localparam int ANGLE_DIV   = 45;
   localparam int ANGLE_BIAS  = 22;
   localparam int FRAC_W      = 21;
   localparam int QUO_W       = 11;
   localparam int REM_W       = $clog2(ANGLE_DIV);
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 23;
   localparam int DIV_PROD_W  = HEAD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] ANGLE_RECIP   = 18'd186414;
   localparam logic [HEAD_W-1:0]  ANGLE_DIV_VAL = 17'd45;

   // CORDIC datapath.
   localparam int ANG_W  = 32;
   localparam int VEC_W  = 32;
   localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic [ANG_W-1:0]        QUARTER_HALF = 32'h2000_0000;

   // Scaling of the step.
   localparam int DIST_W  = AMOUNT_W + 1;
   localparam int PROD_W  = DIST_W + VEC_W;
   localparam int STEP_SHIFT = 30;
   localparam int DELTA_W = PROD_W - STEP_SHIFT;
   localparam logic signed [PROD_W-1:0] STEP_ROUND = 50'sd536870912;

   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

   // Command codes.
   localparam logic MODE_MOVE = 1'b0;
   localparam logic MODE_TURN = 1'b1;
   localparam logic DIR_FWD   = 1'b1;

   // Quadrants of the binary angle.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic [ANG_W-1:0] ATAN_TURN [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef logic [FRAC_W-1:0] frac_tab_type [ANGLE_DIV];

   function automatic frac_tab_type make_frac_tab();
      frac_tab_type t;
      for (int i = 0; i < ANGLE_DIV; i++) begin
         t[i] = FRAC_W'(((longint'(i) << FRAC_W) + ANGLE_BIAS) / ANGLE_DIV);
      end
      return t;
   endfunction

   // Low bits of the binary angle for each remainder of heading / 45, rounded.
   localparam frac_tab_type ANGLE_FRAC = make_frac_tab();

   typedef struct packed {
      logic                mode;
      logic                direction;
      logic [AMOUNT_W-1:0] amount;
   } pdr_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x_out;
      logic signed [POS_W-1:0] pos_y_out;
      logic [HEAD_W-1:0]       heading_out;
   } pdr_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_REMAIN,
      ST_SETUP,
      ST_ROTATE,
      ST_SCALE,
      ST_MOVE_COMMIT,
      ST_TURN_COMMIT
   } pdr_state_type;

   typedef struct packed {
      logic capture;
      logic divide;
      logic remain;
      logic setup;
      logic step;
      logic scale;
      logic move_commit;
      logic turn_commit;
   } pdr_cmd_type;

   typedef struct packed {
      logic step_last;
   } pdr_status_type;

endpackage

`default_nettype wire

// ----- src/pose_dead_reckoning.sv -----
`default_nettype none

// Dead-reckoning pose keeper. The block holds a planar pose (x and y in 1/256 length unit,
// saturating at the signed 32-bit limits, and a heading in 1/256 degree kept in 0 to 92159)
// and takes one command per request beat: a move along the current heading, forward or
// backward, or a rotation counter-clockwise or clockwise that wraps the heading. Every
// command returns exactly one response beat with the pose after it; a rotation leaves the
// positions as they were and a move leaves the heading as it was. Pose registers clear to
// zero on reset. A move passes through these states in order: the divide and remain states
// turn the heading into a binary angle through a reciprocal multiply and a small constant
// table, the setup state loads the CORDIC, the shared shift-and-add stage then does one
// micro-rotation per cycle, the scale state multiplies the distance by cosine and sine, and
// the commit state rounds, adds and saturates. A rotation goes from capture straight to its
// commit. The result sits in an output register, so a new request is taken while a response
// beat waits; a command only stalls at its commit if the previous response beat has still
// not been taken.
module pose_dead_reckoning import pdr_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   input  pdr_req_type req,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output pdr_rsp_type rsp
);

   pdr_cmd_type    cmd;
   pdr_status_type status;

   // The controller sequences the angle conversion, the CORDIC iterations and the commit.
   pdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req.mode),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the pose, the CORDIC registers and the output register.
   pdr_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp)
   );

endmodule

`default_nettype wire

// ----- src/pdr_ctrl.sv -----
`default_nettype none

module pdr_ctrl import pdr_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_mode,
   output logic          req_ready,
   input  wire logic     rsp_ready,
   output logic          rsp_valid,
   input  pdr_status_type status,
   output pdr_cmd_type   cmd
);

   pdr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      out_free = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_mode == MODE_TURN) ? ST_TURN_COMMIT : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_REMAIN;
         end
         ST_REMAIN: begin
            cmd.remain = 1'b1;
            state_in   = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MOVE_COMMIT;
         end
         ST_MOVE_COMMIT: begin
            if (out_free) begin
               cmd.move_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_TURN_COMMIT: begin
            if (out_free) begin
               cmd.turn_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.move_commit || cmd.turn_commit;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- src/pdr_datapath.sv -----
`default_nettype none

module pdr_datapath import pdr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  pdr_req_type    req,
   input  pdr_cmd_type    cmd,
   output pdr_status_type status,
   output pdr_rsp_type    rsp
);

   // Adds a rounded step to a position and clamps to the 32-bit range.
   function automatic logic signed [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0]   a,
      input logic signed [DELTA_W-1:0] d
   );
      logic signed [POS_W:0] s;
      s = $signed({a[POS_W-1], a}) + $signed({{(POS_W+1-DELTA_W){d[DELTA_W-1]}}, d});
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? POS_MIN : POS_MAX;
      end
      return s[POS_W-1:0];
   endfunction

   pdr_req_type             req_ff;
   pdr_rsp_type             rsp_ff, rsp_in;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0] pos_y_ff, pos_y_in;
   logic [HEAD_W-1:0]       heading_ff, heading_in;

   logic [QUO_W-1:0]        quo_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [1:0]              quad_ff;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic signed [VEC_W-1:0] x_ff, x_in;
   logic signed [VEC_W-1:0] y_ff, y_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff;

   logic [DIV_PROD_W-1:0]   div_prod;
   logic [ANG_W-1:0]        bang;
   logic [ANG_W-1:0]        bang_shift;
   logic [ATAN_IDX_W-1:0]   step_idx;
   logic signed [VEC_W-1:0] x_sh, y_sh;
   logic signed [VEC_W-1:0] cos_v, sin_v;
   logic signed [DIST_W-1:0] move_dist;
   logic signed [PROD_W-1:0] prod_x, prod_y;
   logic signed [PROD_W-1:0] sum_x, sum_y;
   logic [HEAD_W-1:0]       delta;
   logic [HEAD_W:0]         turn_sum;
   logic [HEAD_W-1:0]       heading_turn;

   // Heading to binary angle, first by quotient and remainder of 45.
   assign div_prod   = DIV_PROD_W'(heading_ff) * DIV_PROD_W'(ANGLE_RECIP);
   assign bang       = {quo_ff, ANGLE_FRAC[rem_ff]};
   assign bang_shift = bang + QUARTER_HALF;

   // One micro-rotation per cycle.
   assign step_idx    = ATAN_IDX_W'(step_ff);
   assign x_sh        = x_ff >>> step_idx;
   assign y_sh        = y_ff >>> step_idx;
   assign status.step_last = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      if (cmd.setup) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = $signed({{(ANG_W-29){~bang_shift[29]}}, bang_shift[28:0]});
         step_in = '0;
      end else if (cmd.step) begin
         step_in = step_ff + STEP_W'(1);
         if (!z_ff[ANG_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - $signed(ATAN_TURN[step_idx]);
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + $signed(ATAN_TURN[step_idx]);
         end
      end
   end

   // Quadrant turn of the CORDIC result.
   always_comb begin
      case (quad_ff)
         QUAD_0: begin
            cos_v = x_ff;
            sin_v = y_ff;
         end
         QUAD_1: begin
            cos_v = -y_ff;
            sin_v = x_ff;
         end
         QUAD_2: begin
            cos_v = -x_ff;
            sin_v = -y_ff;
         end
         QUAD_3: begin
            cos_v = y_ff;
            sin_v = -x_ff;
         end
         default: begin
            cos_v = x_ff;
            sin_v = y_ff;
         end
      endcase
   end

   assign move_dist = (req_ff.direction == DIR_FWD) ? $signed({1'b0, req_ff.amount})
                                                    : -$signed({1'b0, req_ff.amount});
   assign prod_x = move_dist * cos_v;
   assign prod_y = move_dist * sin_v;
   assign sum_x  = prod_x_ff + STEP_ROUND;
   assign sum_y  = prod_y_ff + STEP_ROUND;

   // Rotation: both reductions need only one compare and subtract.
   assign delta    = (req_ff.amount >= TURN_UNITS) ? req_ff.amount - TURN_UNITS
                                                    : req_ff.amount;
   assign turn_sum = (req_ff.direction == DIR_FWD)
                     ? {1'b0, heading_ff} + {1'b0, delta}
                     : {1'b0, heading_ff} + {1'b0, TURN_UNITS - delta};
   assign heading_turn = (turn_sum >= {1'b0, TURN_UNITS})
                         ? HEAD_W'(turn_sum - {1'b0, TURN_UNITS})
                         : turn_sum[HEAD_W-1:0];

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      rsp_in     = rsp_ff;
      if (cmd.move_commit) begin
         pos_x_in = sat_add(pos_x_ff, sum_x[PROD_W-1:STEP_SHIFT]);
         pos_y_in = sat_add(pos_y_ff, sum_y[PROD_W-1:STEP_SHIFT]);
      end else if (cmd.turn_commit) begin
         heading_in = heading_turn;
      end
      if (cmd.move_commit || cmd.turn_commit) begin
         rsp_in.pos_x_out   = pos_x_in;
         rsp_in.pos_y_out   = pos_y_in;
         rsp_in.heading_out = heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         heading_ff <= '0;
      end else begin
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         heading_ff <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.divide) begin
         quo_ff <= div_prod[RECIP_SHIFT +: QUO_W];
      end
      if (cmd.remain) begin
         rem_ff <= REM_W'(heading_ff - HEAD_W'(quo_ff) * ANGLE_DIV_VAL);
      end
      if (cmd.setup) begin
         quad_ff <= bang_shift[ANG_W-1:ANG_W-2];
      end
      if (cmd.scale) begin
         prod_x_ff <= prod_x;
         prod_y_ff <= prod_y;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ----- src/pdr_checker.sv -----
`default_nettype none

module pdr_checker import pdr_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   input wire logic  req_valid,
   input wire logic  req_ready,
   input wire logic  rsp_valid,
   input wire logic  rsp_ready,
   input pdr_rsp_type rsp
);

   // No response is pending straight after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat valid after reset");

   // Commands are handled one at a time: an accepted request makes the block busy.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a command is in progress");

   // The reported heading is always wrapped into one turn.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.heading_out < TURN_UNITS))
      else $error("heading out of range");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled response beat changed");

endmodule

bind pose_dead_reckoning pdr_checker u_pdr_checker (.*);

`default_nettype wire
